/* hdl/tsrw_pkg.sv */
// Package for the timestamp run window counter.
// Holds the sizing constants, status and request codes, sequencer states and the
// run store write bundle. No dependencies.
package tsrw_pkg;

   localparam int RUN_DEPTH  = 64;
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int IDX_BITS   = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int USED_BITS  = $clog2(RUN_DEPTH + 1);

   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(RUN_DEPTH - 1);
   localparam logic [USED_BITS-1:0]  FULL_USED = USED_BITS'(RUN_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_EVICT = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OLD_DROP  = 2'd1;
   localparam logic [1:0] STATUS_FULL_DROP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   addr;
      logic [TIME_BITS-1:0]  time_value;
      logic [COUNT_BITS-1:0] count;
   } run_wr_type;

endpackage

/* hdl/timestamp_run_window_counter_core.sv */
// Timestamp run window counter: a request is taken only in the idle state, goes through the
// execute state, and its result is registered in the response state; no new request is taken
// until that result has moved into the output register. An evict that clears the store goes
// straight to the response state; any other evict walks the store one run per cycle through
// one registered read port and one shared time comparator. Reset is synchronous and active
// high; it empties the store and clears the total. Depends on tsrw_pkg and tsrw_run_mem.
module timestamp_run_window_counter_core
   import tsrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_time_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_total_events,
   output logic [6:0]  rsp_runs_in_use,
   output logic [31:0] rsp_oldest_time
);

   state_type state_ff, state_in;

   logic                  req_type_ff, req_type_in;
   logic [TIME_BITS-1:0]  req_time_ff, req_time_in;
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic [IDX_BITS-1:0]   tail_ff, tail_in;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [TIME_BITS-1:0]  newest_time_ff, newest_time_in;
   logic [COUNT_BITS-1:0] newest_count_ff, newest_count_in;
   logic [TIME_BITS-1:0]  head_time_ff, head_time_in;
   logic [1:0]            status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_total_ff, rsp_total_in;
   logic [6:0]  rsp_runs_ff, rsp_runs_in;
   logic [31:0] rsp_oldest_ff, rsp_oldest_in;

   run_wr_type            mem_wr;
   logic [TIME_BITS-1:0]  rd_time;
   logic [COUNT_BITS-1:0] rd_count;

   logic                  accept;
   logic                  rsp_free;
   logic                  empty;
   logic [TIME_BITS-1:0]  cmp_lhs;
   logic                  cmp_lt;
   logic                  cmp_eq;
   logic [IDX_BITS-1:0]   newest_idx;
   logic [IDX_BITS-1:0]   head_next;
   logic [IDX_BITS-1:0]   tail_next;
   logic [COUNT_BITS-1:0] total_bump;

   tsrw_run_mem u_run_mem (
      .clock    (clock),
      .wr       (mem_wr),
      .rd_addr  (head_in),
      .rd_time  (rd_time),
      .rd_count (rd_count)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign empty     = (used_ff == '0);

   // The one time comparator is shared by the add check, the stale check and the walk.
   assign cmp_lhs = (state_ff == ST_WALK) ? rd_time : newest_time_ff;
   assign cmp_lt  = (cmp_lhs < req_time_ff);
   assign cmp_eq  = (cmp_lhs == req_time_ff);

   assign newest_idx = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign head_next  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign total_bump = (total_ff == COUNT_MAX) ? total_ff : total_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_type_ff == REQ_EVICT && !empty && !cmp_lt) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WALK: begin
            if (!cmp_lt) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_type_in     = req_type_ff;
      req_time_in     = req_time_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      used_in         = used_ff;
      total_in        = total_ff;
      newest_time_in  = newest_time_ff;
      newest_count_in = newest_count_ff;
      head_time_in    = head_time_ff;
      status_in       = status_ff;
      mem_wr          = '0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_runs_in     = rsp_runs_ff;
      rsp_oldest_in   = rsp_oldest_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_type_in = req_type;
               req_time_in = TIME_BITS'(req_time_value);
            end
         end
         ST_EXEC: begin
            status_in = STATUS_DONE;
            if (req_type_ff == REQ_EVICT) begin
               if (empty || cmp_lt) begin
                  head_in  = '0;
                  tail_in  = '0;
                  used_in  = '0;
                  total_in = '0;
               end
            end else if (!empty && !cmp_lt && !cmp_eq) begin
               status_in = STATUS_OLD_DROP;
            end else if (!empty && cmp_eq) begin
               if (newest_count_ff != COUNT_MAX) begin
                  newest_count_in = newest_count_ff + 1'b1;
               end
               total_in          = total_bump;
               mem_wr.en         = 1'b1;
               mem_wr.addr       = newest_idx;
               mem_wr.time_value = newest_time_ff;
               mem_wr.count      = newest_count_in;
            end else if (used_ff == FULL_USED) begin
               status_in = STATUS_FULL_DROP;
            end else begin
               mem_wr.en         = 1'b1;
               mem_wr.addr       = tail_ff;
               mem_wr.time_value = req_time_ff;
               mem_wr.count      = COUNT_BITS'(1);
               tail_in           = tail_next;
               used_in           = used_ff + 1'b1;
               total_in          = total_bump;
               newest_time_in    = req_time_ff;
               newest_count_in   = COUNT_BITS'(1);
               if (empty) begin
                  head_time_in = req_time_ff;
               end
            end
         end
         ST_WALK: begin
            if (cmp_lt) begin
               total_in = (total_ff >= rd_count) ? total_ff - rd_count : '0;
               head_in  = head_next;
               used_in  = used_ff - 1'b1;
            end else begin
               head_time_in = rd_time;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = 32'(total_ff);
               rsp_runs_in   = 7'(used_ff);
               rsp_oldest_in = empty ? '0 : 32'(head_time_ff);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff     <= req_type_in;
      req_time_ff     <= req_time_in;
      newest_time_ff  <= newest_time_in;
      newest_count_ff <= newest_count_in;
      head_time_ff    <= head_time_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_runs_ff     <= rsp_runs_in;
      rsp_oldest_ff   <= rsp_oldest_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_events = rsp_total_ff;
   assign rsp_runs_in_use  = rsp_runs_ff;
   assign rsp_oldest_time  = rsp_oldest_ff;

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL_USED)
      else $error("Run count exceeds the store depth.");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      (used_ff == '0) |-> (head_ff == tail_ff))
      else $error("Empty store with head and tail apart.");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (used_ff != '0))
      else $error("Eviction walk on an empty store.");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("Accepted transaction did not start execution.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_DONE || rsp_status_ff == STATUS_OLD_DROP
                        || rsp_status_ff == STATUS_FULL_DROP))
      else $error("Result carries an undefined status.");
`endif

endmodule

/* hdl/tsrw_run_mem.sv */
// Run store of the timestamp run window counter: one write port, one read port
// with registered read data. Depends on tsrw_pkg.
module tsrw_run_mem
   import tsrw_pkg::*;
(
   input  logic                  clock,
   input  run_wr_type            wr,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [TIME_BITS-1:0]  rd_time,
   output logic [COUNT_BITS-1:0] rd_count
);

   logic [TIME_BITS-1:0]  run_time_ff  [RUN_DEPTH];
   logic [COUNT_BITS-1:0] run_count_ff [RUN_DEPTH];
   logic [TIME_BITS-1:0]  rd_time_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         run_time_ff[wr.addr]  <= wr.time_value;
         run_count_ff[wr.addr] <= wr.count;
      end
   end

   always_ff @(posedge clock) begin
      rd_time_ff  <= run_time_ff[rd_addr];
      rd_count_ff <= run_count_ff[rd_addr];
   end

   assign rd_time  = rd_time_ff;
   assign rd_count = rd_count_ff;

endmodule

/* bench/window_report_checker.sv */
`timescale 1ns / 100ps
// Checker for the timestamp run window counter: watches both channels, keeps its own
// copy of the run ring and event total, and compares every result transaction.
// Depends on tsrw_pkg.
module window_report_checker
   import tsrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_time_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_total_events,
   input  logic [6:0]  rsp_runs_in_use,
   input  logic [31:0] rsp_oldest_time,
   output int          mismatch_count,
   output int          reports_pending,
   output int          reports_checked,
   output int          order_drops,
   output int          full_drops,
   output int          window_clears,
   output int          partial_evicts
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] total_events;
      logic [6:0]  runs_in_use;
      logic [31:0] oldest_time;
   } window_report_type;

   logic [TIME_BITS-1:0]  run_time_q  [RUN_DEPTH];
   logic [COUNT_BITS-1:0] run_count_q [RUN_DEPTH];
   logic [IDX_BITS-1:0]   head_q;
   logic [IDX_BITS-1:0]   tail_q;
   int unsigned           used_q;
   logic [COUNT_BITS-1:0] total_q;
   window_report_type     expected_reports [$];

   function automatic logic [IDX_BITS-1:0] next_slot(input logic [IDX_BITS-1:0] slot);
      return (slot == LAST_IDX) ? '0 : slot + 1'b1;
   endfunction

   function automatic window_report_type apply_request(input logic kind,
                                                       input logic [TIME_BITS-1:0] stamp);
      window_report_type   report;
      logic [IDX_BITS-1:0] newest;
      report.status = STATUS_DONE;
      newest = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
      if (kind == REQ_ADD) begin
         if (used_q != 0 && run_time_q[newest] > stamp) begin
            report.status = STATUS_OLD_DROP;
         end else if (used_q != 0 && run_time_q[newest] == stamp) begin
            if (run_count_q[newest] != COUNT_MAX) begin
               run_count_q[newest] = run_count_q[newest] + 1'b1;
            end
            if (total_q != COUNT_MAX) total_q = total_q + 1'b1;
         end else if (used_q >= RUN_DEPTH) begin
            report.status = STATUS_FULL_DROP;
         end else begin
            run_time_q[tail_q]  = stamp;
            run_count_q[tail_q] = COUNT_BITS'(1);
            tail_q = next_slot(tail_q);
            used_q++;
            if (total_q != COUNT_MAX) total_q = total_q + 1'b1;
         end
      end else if (used_q == 0 || run_time_q[newest] < stamp) begin
         head_q  = '0;
         tail_q  = '0;
         used_q  = 0;
         total_q = '0;
      end else begin
         while (used_q != 0 && run_time_q[head_q] < stamp) begin
            total_q = (total_q >= run_count_q[head_q]) ? total_q - run_count_q[head_q] : '0;
            head_q = next_slot(head_q);
            used_q--;
         end
      end
      report.total_events = total_q;
      report.runs_in_use  = 7'(used_q);
      report.oldest_time  = (used_q != 0) ? 32'(run_time_q[head_q]) : '0;
      return report;
   endfunction

   always @(posedge clock) begin : checking
      window_report_type got;
      window_report_type want;
      int unsigned       used_before;
      if (reset) begin
         head_q  = '0;
         tail_q  = '0;
         used_q  = 0;
         total_q = '0;
         expected_reports.delete();
         reports_pending <= 0;
      end else begin
         if (req_valid && req_ready) begin
            used_before = used_q;
            want = apply_request(req_type, TIME_BITS'(req_time_value));
            expected_reports.insert(expected_reports.size(), want);
            if (want.status == STATUS_OLD_DROP) order_drops <= order_drops + 1;
            if (want.status == STATUS_FULL_DROP) full_drops <= full_drops + 1;
            if (req_type == REQ_EVICT && used_q == 0) begin
               window_clears <= window_clears + 1;
            end else if (req_type == REQ_EVICT && used_q < used_before) begin
               partial_evicts <= partial_evicts + 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_total_events, rsp_runs_in_use, rsp_oldest_time};
            reports_checked <= reports_checked + 1;
            if (expected_reports.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Result transaction with nothing pending: %s %0d %0d %0d %h",
                           "status, total, runs, oldest", got.status, got.total_events,
                           got.runs_in_use, got.oldest_time);
            end else begin
               want = expected_reports.pop_front();
               if (got.status !== want.status || got.total_events !== want.total_events ||
                   got.runs_in_use !== want.runs_in_use ||
                   got.oldest_time !== want.oldest_time) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("Mismatch at %0t: expected status %0d total %0d runs %0d oldest %h",
                              $realtime, want.status, want.total_events, want.runs_in_use,
                              want.oldest_time);
                     $display("   actual: status %0d total %0d runs %0d oldest %h",
                              got.status, got.total_events, got.runs_in_use, got.oldest_time);
                  end
               end
            end
         end
         reports_pending <= expected_reports.size();
      end
   end

endmodule

/* bench/tb_timestamp_run_window_counter_core.sv */
`timescale 1ns / 100ps
// Testbench top for the timestamp run window counter core: drives add and evict
// transactions with random gaps and result stalls and reports the verdict.
// Depends on tsrw_pkg, timestamp_run_window_counter_core and window_report_checker.
module tb_timestamp_run_window_counter_core
   import tsrw_pkg::*;
();

   localparam int RANDOM_ITEMS  = 1480;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 100;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_type       = REQ_ADD;
   logic [31:0] req_time_value = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_total_events;
   logic [6:0]  rsp_runs_in_use;
   logic [31:0] rsp_oldest_time;

   int mismatch_count;
   int reports_pending;
   int reports_checked;
   int order_drops;
   int full_drops;
   int window_clears;
   int partial_evicts;
   int items_sent    = 0;
   int hold_requests = 0;
   bit sender_burst  = 1'b0;

   timestamp_run_window_counter_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_total_events (rsp_total_events),
      .rsp_runs_in_use  (rsp_runs_in_use),
      .rsp_oldest_time  (rsp_oldest_time)
   );

   window_report_checker u_report_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_total_events (rsp_total_events),
      .rsp_runs_in_use  (rsp_runs_in_use),
      .rsp_oldest_time  (rsp_oldest_time),
      .mismatch_count   (mismatch_count),
      .reports_pending  (reports_pending),
      .reports_checked  (reports_checked),
      .order_drops      (order_drops),
      .full_drops       (full_drops),
      .window_clears    (window_clears),
      .partial_evicts   (partial_evicts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   task automatic send_request(input logic kind, input logic [31:0] stamp);
      int gap;
      gap = sender_burst ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_time_value <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (items_sent == 300 || items_sent == 1000) hold_requests <= hold_requests + 1;
      if (items_sent == 650 || items_sent == 1350) wait_for_drain();
   endtask

   initial begin : result_side
      int served;
      int stall_left;
      int phase_left;
      bit steady;
      served     = 0;
      stall_left = 0;
      phase_left = 0;
      steady     = 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            steady     = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(100, 600);
         end else begin
            phase_left--;
         end
         if (hold_requests != served) begin
            served     = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (steady || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = idle_length();
         end
      end
   end

   initial begin : stimulus
      logic [31:0] newest;
      logic [31:0] stamp;
      int          run_len;
      int          roll;
      int          step;
      bit          filling;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_EVICT, 32'h0000_0000);
      send_request(REQ_EVICT, 32'hFFFF_FFFF);
      send_request(REQ_ADD,   32'd0);
      send_request(REQ_ADD,   32'd0);
      send_request(REQ_ADD,   32'd10);
      send_request(REQ_ADD,   32'd9);
      send_request(REQ_ADD,   32'd0);
      send_request(REQ_ADD,   32'd20);
      send_request(REQ_EVICT, 32'd0);
      send_request(REQ_EVICT, 32'd10);
      send_request(REQ_EVICT, 32'd20);
      send_request(REQ_EVICT, 32'd21);
      send_request(REQ_ADD,   32'hFFFF_FFFE);
      send_request(REQ_ADD,   32'hFFFF_FFFE);
      send_request(REQ_ADD,   32'h7FFF_FFFF);
      send_request(REQ_EVICT, 32'hFFFF_FFFE);
      send_request(REQ_EVICT, 32'hFFFF_FFFF);
      send_request(REQ_ADD,   32'd5);
      send_request(REQ_EVICT, 32'd5);
      send_request(REQ_ADD,   32'd6);
      send_request(REQ_EVICT, 32'd6);
      send_request(REQ_EVICT, 32'd7);

      while (items_sent < 22 + RANDOM_ITEMS) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         filling      = ($urandom_range(0, 5) == 0);
         run_len      = filling ? $urandom_range(70, 90) : $urandom_range(5, 40);
         roll         = $urandom_range(0, 2);
         newest       = (roll == 0) ? $urandom_range(0, 100) : $urandom_range(0, 32'hFFFF_F000);
         for (int i = 0; i < run_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 15 : 40)) begin
               send_request(REQ_ADD, newest);
            end else if (filling || roll < 68) begin
               step = $urandom_range(1, 4);
               if (newest < 32'hFFFF_FFFE - step) newest = newest + step;
               send_request(REQ_ADD, newest);
            end else if (roll < 72) begin
               stamp = $urandom_range(0, 32'hFFFF_FFFE);
               if (stamp > newest) newest = stamp;
               send_request(REQ_ADD, stamp);
            end else if (roll < 78) begin
               step  = $urandom_range(1, 64);
               stamp = (newest >= step) ? newest - step : '0;
               send_request(REQ_ADD, stamp);
            end else if (roll < 93) begin
               step  = $urandom_range(0, 40);
               stamp = (newest >= step) ? newest - step : '0;
               send_request(REQ_EVICT, stamp);
            end else begin
               step  = $urandom_range(1, 100);
               stamp = (newest < 32'hFFFF_FFFF - step) ? newest + step : 32'hFFFF_FFFF;
               send_request(REQ_EVICT, stamp);
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            send_request(REQ_EVICT, 32'hFFFF_FFFF);
         end else begin
            step  = $urandom_range(1, 1000);
            stamp = (newest < 32'hFFFF_FFFF - step) ? newest + step : 32'hFFFF_FFFF;
            send_request(REQ_EVICT, stamp);
         end
      end

      sender_burst = 1'b0;
      send_request(REQ_ADD,   32'hFFFF_FFFF);
      send_request(REQ_ADD,   32'hFFFF_FFFF);
      send_request(REQ_ADD,   32'h0000_0000);
      send_request(REQ_EVICT, 32'hFFFF_FFFF);
      send_request(REQ_EVICT, 32'h0000_0000);
      send_request(REQ_ADD,   32'hFFFF_FFFE);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d results over %0d transactions: %0d out-of-order drops, %0d full drops,",
               reports_checked, items_sent, order_drops, full_drops);
      $display("%0d evictions that emptied the store and %0d that removed only the oldest runs.",
               window_clears, partial_evicts);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
